// File: hw/rtl/bae_pkg.sv
// shared types and constants for the byte arithmetic encoder
// used by bae_cum_table and byte_arithmetic_encoder; no dependencies
package bae_pkg;

  // default depth of the cumulative frequency table
  localparam int MAX_SYMBOLS_DEF = 256;

  // operation codes of an input transaction
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CARRY  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic REG_SYMBOL_COUNT = 1'b0;

  // interval arithmetic constants
  localparam logic [31:0] END_TOP      = 32'hFFFF_FEFF;
  localparam logic [31:0] HALF_DIGIT   = 32'h0080_0000;
  localparam logic [31:0] FLUSH_LENGTH = 32'h0000_FFFF;
  localparam logic [31:0] LENGTH_RESET = 32'hFFFF_FFFF;

  // input transaction payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  table_index;
    logic [31:0] table_value;
    logic [7:0]  symbol;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

endpackage

// File: hw/rtl/bae_cum_table.sv
// cumulative frequency table: one write port, one registered read port
// entries at or above MAX_SYMBOLS are never stored and read as zero
module bae_cum_table #(
  parameter int MAX_SYMBOLS = bae_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [7:0]  wr_index,
  input  logic [31:0] wr_value,
  input  logic [8:0]  rd_index,
  output logic [31:0] rd_value
);

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [31:0]   mem [MAX_SYMBOLS];
  logic [31:0]   rd_q_r;
  logic          rd_in_range_r;
  logic          wr_in_range;
  logic          rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // range checks and address truncation
  assign wr_in_range = 32'(wr_index) < 32'(MAX_SYMBOLS);
  assign rd_in_range = 32'(rd_index) < 32'(MAX_SYMBOLS);
  assign wr_addr     = AW'(wr_index);
  assign rd_addr     = AW'(rd_index);

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr] <= wr_value;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_q_r        <= mem[rd_addr];
    rd_in_range_r <= rd_in_range;
  end

  assign rd_value = rd_in_range_r ? rd_q_r : 32'd0;

endmodule

// File: hw/rtl/byte_arithmetic_encoder.sv
// byte arithmetic encoder top level: sequencer, shared multiplier, interval
// registers and apb register; depends on bae_pkg and bae_cum_table
//
// Usage: input transactions arrive on in_valid/in_ready with an
// in_item_t payload: a load writes one cumulative table entry, an encode
// narrows the interval by one symbol, a finish codes the end symbol and
// flushes the last bytes. Each input yields one or more results on
// out_valid/out_ready (byte, carry marker or status only); the final one
// carries last. symbol_count is written through the apb port at byte
// address 0; the user must do so only while the block is idle, as the
// block itself does not enforce it.
// Timing: one input is worked on at a time and in_ready is low meanwhile.
// An encode uses the single 32x32 multiplier twice and a table read per
// bound. The next input is taken only after the last result has been
// loaded into the output register.
// Reset: rst_n clears the interval, the error flag, symbol_count to 1 and
// the output valid flag; table contents are undefined until loaded.
// Stalls: while out_ready is low the held result stays put and the
// sequencer waits before loading the next one.
module byte_arithmetic_encoder #(
  parameter int MAX_SYMBOLS = bae_pkg::MAX_SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bae_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bae_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDHI  = 4'd2;
  localparam logic [3:0] S_MULHI = 4'd3;
  localparam logic [3:0] S_MULLO = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_REN   = 4'd7;
  localparam logic [3:0] S_FADD  = 4'd8;
  localparam logic [3:0] S_STAT  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [31:0] val_r, val_nxt;
  logic [7:0]  sym_r, sym_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        any_r, any_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  count_r;
  logic [63:0] prod_r, prod_nxt;
  logic        out_valid_r, out_valid_nxt;
  bae_pkg::out_item_t out_data_r, out_data_nxt;

  logic        out_free;
  logic        emit;
  logic        tbl_wr;
  logic [8:0]  tbl_rd_index;
  logic [31:0] tbl_rd_value;
  logic [31:0] mul_operand;
  logic [63:0] mul_prod;
  logic [31:0] lo_cur;
  logic [32:0] diff;
  logic [31:0] addend;
  logic [32:0] sum;
  logic        need_ren;
  logic [31:0] len_shift;
  logic        need_ren_after;
  logic [8:0]  sym_hi;
  logic        cfg_wr;

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bae_pkg::REG_SYMBOL_COUNT);
  assign prdata = (paddr[2] == bae_pkg::REG_SYMBOL_COUNT) ? {24'd0, count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd1;
    end else if (cfg_wr) begin
      count_r <= pwdata[7:0];
    end
  end

  // cumulative table
  assign sym_hi       = {1'b0, sym_r} + 9'd1;
  assign tbl_rd_index = (state_r == S_RDHI) ? sym_hi : {1'b0, sym_r};
  assign tbl_wr       = (state_r == S_DISP) && (op_r == bae_pkg::OP_LOAD);

  bae_cum_table #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_table (
    .clk      (clk),
    .wr_en    (tbl_wr),
    .wr_index (idx_r),
    .wr_value (val_r),
    .rd_index (tbl_rd_index),
    .rd_value (tbl_rd_value)
  );

  // shared multiplier operand: the top entry reads as the fixed value
  always_comb begin
    mul_operand = tbl_rd_value;
    if (state_r == S_MULHI) begin
      if (sym_hi == {1'b0, count_r}) begin
        mul_operand = bae_pkg::END_TOP;
      end
    end else if (sym_r == count_r) begin
      mul_operand = bae_pkg::END_TOP;
    end
  end

  // single 32x32 multiplier shared by both bounds
  assign mul_prod = 64'(len_r) * 64'(mul_operand);

  // interval datapath pieces
  assign lo_cur         = prod_r[63:32];
  assign diff           = {1'b0, hi_r} - {1'b0, lo_cur};
  assign addend         = (state_r == S_FADD) ? bae_pkg::HALF_DIGIT : lo_r;
  assign sum            = {1'b0, base_r} + {1'b0, addend};
  assign need_ren       = (len_r[31:24] == 8'd0) && (len_r != 32'd0);
  assign len_shift      = {len_r[23:0], 8'd0};
  assign need_ren_after = (len_shift[31:24] == 8'd0) && (len_shift != 32'd0);
  assign out_free       = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    val_nxt      = val_r;
    sym_nxt      = sym_r;
    stat_nxt     = stat_r;
    any_nxt      = any_r;
    phase_nxt    = phase_r;
    base_nxt     = base_r;
    len_nxt      = len_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    err_nxt      = err_r;
    prod_nxt     = prod_r;
    emit         = 1'b0;
    out_data_nxt = out_data_r;

    unique case (state_r)
      // wait for an input transaction
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          idx_nxt   = in_data.table_index;
          val_nxt   = in_data.table_value;
          sym_nxt   = in_data.symbol;
          any_nxt   = 1'b0;
          phase_nxt = 1'b0;
          state_nxt = S_DISP;
        end
      end
      // decode the operation
      S_DISP: begin
        stat_nxt  = err_r ? bae_pkg::ST_ZERO : bae_pkg::ST_OK;
        state_nxt = S_STAT;
        if (!err_r) begin
          if (op_r == bae_pkg::OP_ENCODE) begin
            if (sym_r > count_r) begin
              stat_nxt = bae_pkg::ST_RANGE;
            end else begin
              state_nxt = S_RDHI;
            end
          end else if (op_r == bae_pkg::OP_FINISH) begin
            sym_nxt   = count_r;
            state_nxt = S_RDHI;
          end
        end
      end
      // table read of the upper bound entry
      S_RDHI: begin
        state_nxt = S_MULHI;
      end
      // upper bound product
      S_MULHI: begin
        prod_nxt  = mul_prod;
        state_nxt = S_MULLO;
      end
      // lower bound product
      S_MULLO: begin
        hi_nxt    = (sym_r == count_r) ? len_r : prod_r[63:32];
        prod_nxt  = mul_prod;
        state_nxt = S_CHK;
      end
      // empty interval check and new length
      S_CHK: begin
        if (diff[32] || (diff[31:0] == 32'd0)) begin
          stat_nxt  = bae_pkg::ST_ZERO;
          state_nxt = S_STAT;
        end else begin
          len_nxt   = diff[31:0];
          lo_nxt    = lo_cur;
          state_nxt = S_ADD;
        end
      end
      // move the base up, carry marker on wrap
      S_ADD, S_FADD: begin
        if (!sum[32] || out_free) begin
          base_nxt = sum[31:0];
          if (sum[32]) begin
            emit                  = 1'b1;
            any_nxt               = 1'b1;
            out_data_nxt.kind     = bae_pkg::KIND_CARRY;
            out_data_nxt.out_byte = 8'd0;
            out_data_nxt.status   = bae_pkg::ST_OK;
            out_data_nxt.last     = (state_r == S_ADD) && (op_r == bae_pkg::OP_ENCODE)
                                    && !need_ren;
          end
          if (state_r == S_FADD) begin
            len_nxt   = bae_pkg::FLUSH_LENGTH;
            phase_nxt = 1'b1;
          end
          state_nxt = S_REN;
        end
      end
      // renormalise one byte at a time
      S_REN: begin
        if (need_ren) begin
          if (out_free) begin
            emit                  = 1'b1;
            any_nxt               = 1'b1;
            out_data_nxt.kind     = bae_pkg::KIND_BYTE;
            out_data_nxt.out_byte = base_r[31:24];
            out_data_nxt.status   = bae_pkg::ST_OK;
            out_data_nxt.last     = ((op_r == bae_pkg::OP_ENCODE) || phase_r)
                                    && !need_ren_after;
            len_nxt               = len_shift;
            base_nxt              = {base_r[23:0], 8'd0};
          end
        end else if (op_r == bae_pkg::OP_ENCODE) begin
          if (any_r) begin
            state_nxt = S_IDLE;
          end else begin
            stat_nxt  = bae_pkg::ST_OK;
            state_nxt = S_STAT;
          end
        end else if (!phase_r) begin
          state_nxt = S_FADD;
        end else begin
          base_nxt  = 32'd0;
          len_nxt   = bae_pkg::LENGTH_RESET;
          err_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      // single status-only result
      S_STAT: begin
        if (out_free) begin
          emit                  = 1'b1;
          out_data_nxt.kind     = bae_pkg::KIND_STATUS;
          out_data_nxt.out_byte = 8'd0;
          out_data_nxt.status   = stat_r;
          out_data_nxt.last     = 1'b1;
          if (op_r == bae_pkg::OP_FINISH) begin
            base_nxt = 32'd0;
            len_nxt  = bae_pkg::LENGTH_RESET;
            err_nxt  = 1'b0;
          end else if (stat_r != bae_pkg::ST_OK) begin
            err_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= 32'd0;
      len_r       <= bae_pkg::LENGTH_RESET;
      err_r       <= 1'b0;
      any_r       <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      len_r       <= len_nxt;
      err_r       <= err_nxt;
      any_r       <= any_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    sym_r      <= sym_nxt;
    stat_r     <= stat_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
